// ===== hw/rtl/mtpg_pkg.sv =====
// constants and state encoding for the mt19937 probability gate
`timescale 1ns / 1ps

package mtpg_pkg;

  localparam int unsigned TwLen   = 624;
  localparam int unsigned TwMid   = 397;
  localparam int unsigned IdxW    = $clog2(TwLen + 2);

  localparam logic [IdxW-1:0] TwLast    = IdxW'(TwLen - 1);
  localparam logic [IdxW-1:0] IdxFull   = IdxW'(TwLen);
  localparam logic [IdxW-1:0] IdxNever  = IdxW'(TwLen + 1);
  localparam logic [IdxW-1:0] TwWrap    = IdxW'(TwLen - TwMid);
  localparam logic [IdxW-1:0] TwMidIdx  = IdxW'(TwMid);

  localparam logic [31:0] TwMat       = 32'h9908_b0df;
  localparam logic [31:0] TwHi        = 32'h8000_0000;
  localparam logic [31:0] TwLo        = 32'h7fff_ffff;
  localparam logic [31:0] TwMult      = 32'd1812433253;
  localparam logic [31:0] TempMaskB   = 32'h9d2c_5680;
  localparam logic [31:0] TempMaskC   = 32'hefc6_0000;
  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] SeedMax     = 32'd99;

  localparam logic KindReseed = 1'b0;
  localparam logic KindDraw   = 1'b1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StSeed  = 9'b000000010,
    StTwPre = 9'b000000100,
    StTwLd  = 9'b000001000,
    StTwRd  = 9'b000010000,
    StTwWr  = 9'b000100000,
    StDrRd  = 9'b001000000,
    StDrTmp = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  // output tempering of one state word
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TempMaskB);
    y = y ^ ((y << 15) & TempMaskC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mt19937_probability_gate.sv =====
// mt19937 generator with probability gate decision, top level
`timescale 1ns / 1ps

// MT19937 probability gate. Each request is either a reseed (kind 0) or a
// draw (kind 1), and each gives exactly one result. A reseed clamps the seed
// to 0..99 (negative seeds count as large and become 99), runs the standard
// initialisation over all 624 state words at one word per cycle through a
// single 32x32 multiplier, and returns random_word = 0, gate = 0. A draw
// returns the next tempered word and gate = 1 when that word is below the
// 33-bit threshold. A draw does a registered state-memory read, then
// tempering and compare. The first draw after seeding, and every 624th
// draw after that, first regenerates the whole state in place, word by
// word (read of the next and the far word on the two memory read ports,
// then the write). A draw with no reseed since reset first seeds with
// 5489, adding the seeding pass as well. One request is in flight at a
// time: in_stall_o is high from acceptance until the result has been
// moved into the output register, which then waits for the consumer while
// the next request may already be accepted.
module mt19937_probability_gate
  import mtpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] seed_i,
  input  logic        [32:0] threshold_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [31:0] random_word_o,
  output logic               gate_o
);

  // twister state memory, one write port and two registered read ports
  logic [31:0] mem_q [TwLen];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;
  logic [IdxW-1:0] raddr_a, raddr_b;
  logic [31:0]     rd_a_q, rd_b_q;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;     // word index, IdxNever after reset
  logic [IdxW-1:0] cnt_q, cnt_d;     // seeding / twist position
  logic [31:0]     cur_q, cur_d;     // last seeded word, or current twist word
  logic            kind_q, kind_d;
  logic [32:0]     thr_q, thr_d;
  logic [31:0]     res_word_q, res_word_d;
  logic            res_gate_q, res_gate_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_word_q, out_word_d;
  logic            out_gate_q, out_gate_d;

  logic            in_acc;
  logic [31:0]     seed_sat;
  logic [31:0]     seed_mix;
  logic [31:0]     seed_next;
  logic [IdxW-1:0] tw_nxt, tw_far;
  logic [31:0]     tw_y;
  logic [31:0]     tw_v;
  logic [31:0]     tempered;
  logic            out_free;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  // negative seeds read as huge unsigned values and clamp too
  assign seed_sat = (unsigned'(seed_i) > SeedMax) ? SeedMax : unsigned'(seed_i);

  // initialisation recurrence, one multiply per cycle
  assign seed_mix  = cur_q ^ (cur_q >> 30);
  assign seed_next = 32'(TwMult * seed_mix) + 32'(cnt_q);

  // twist neighbors of position cnt_q
  assign tw_nxt = (cnt_q == TwLast) ? '0 : cnt_q + IdxW'(1);
  assign tw_far = (cnt_q >= TwWrap) ? cnt_q - TwWrap : cnt_q + TwMidIdx;
  assign tw_y   = (cur_q & TwHi) | (rd_a_q & TwLo);
  assign tw_v   = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? TwMat : 32'd0);

  assign tempered = temper(rd_a_q);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    kind_d      = kind_q;
    thr_d       = thr_q;
    res_word_d  = res_word_q;
    res_gate_d  = res_gate_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_gate_d  = out_gate_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = seed_next;
    raddr_a     = tw_nxt;
    raddr_b     = tw_far;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          kind_d = kind_i;
          thr_d  = threshold_i;
          if (kind_i == KindReseed || idx_q == IdxNever) begin
            // first state word is the seed itself
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = (kind_i == KindReseed) ? seed_sat : DefaultSeed;
            cur_d     = mem_wdata;
            cnt_d     = IdxW'(1);
            state_d   = StSeed;
          end else if (idx_q == IdxFull) begin
            cnt_d   = '0;
            state_d = StTwPre;
          end else begin
            state_d = StDrRd;
          end
        end
      end
      StSeed: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = seed_next;
        cur_d     = seed_next;
        cnt_d     = cnt_q + IdxW'(1);
        if (cnt_q == TwLast) begin
          idx_d = IdxFull;
          if (kind_q == KindDraw) begin
            cnt_d   = '0;
            state_d = StTwPre;
          end else begin
            res_word_d = '0;
            res_gate_d = 1'b0;
            state_d    = StDone;
          end
        end
      end
      StTwPre: begin
        // fetch word 0 as the first current word
        raddr_a = '0;
        state_d = StTwLd;
      end
      StTwLd: begin
        cur_d   = rd_a_q;
        state_d = StTwRd;
      end
      StTwRd: begin
        raddr_a = tw_nxt;
        raddr_b = tw_far;
        state_d = StTwWr;
      end
      StTwWr: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = tw_v;
        cur_d     = rd_a_q;     // next word becomes the current one
        cnt_d     = cnt_q + IdxW'(1);
        if (cnt_q == TwLast) begin
          idx_d   = '0;
          state_d = StDrRd;
        end else begin
          state_d = StTwRd;
        end
      end
      StDrRd: begin
        raddr_a = idx_q;
        idx_d   = idx_q + IdxW'(1);
        state_d = StDrTmp;
      end
      StDrTmp: begin
        res_word_d = tempered;
        res_gate_d = ({1'b0, tempered} < thr_q);
        state_d    = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = res_word_q;
          out_gate_d  = res_gate_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= IdxNever;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    cur_q      <= cur_d;
    kind_q     <= kind_d;
    thr_q      <= thr_d;
    res_word_q <= res_word_d;
    res_gate_q <= res_gate_d;
    out_word_q <= out_word_d;
    out_gate_q <= out_gate_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;
  assign gate_o        = out_gate_q;

endmodule

// ===== dv/mtpg_gate_checker.sv =====
// scoreboard for the mt19937 probability gate: predicts every request and checks its result
`timescale 1ns / 1ps

module mtpg_gate_checker
  import mtpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               kind_i,
  input  logic signed [31:0] seed_i,
  input  logic        [32:0] threshold_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic        [31:0] random_word_i,
  input  logic               gate_i,
  output int unsigned        fail_count_o,
  output int unsigned        open_count_o
);

  localparam int unsigned StateLen    = 624;
  localparam int unsigned ShiftSpan   = 397;
  localparam int unsigned NeverSeeded = 625;

  localparam logic [31:0] MatrixA   = 32'h9908_b0df;
  localparam logic [31:0] UpperMask = 32'h8000_0000;
  localparam logic [31:0] LowerMask = 32'h7fff_ffff;
  localparam logic [31:0] InitMult  = 32'd1812433253;
  localparam logic [31:0] TemperB   = 32'h9d2c_5680;
  localparam logic [31:0] TemperC   = 32'hefc6_0000;
  localparam logic [31:0] BootSeed  = 32'd5489;
  localparam logic [31:0] SeedCeil  = 32'd99;

  typedef struct packed {
    logic [31:0] word;
    logic        gate;
  } gate_result_t;

  logic [31:0]  mt_words [StateLen];
  int unsigned  mt_pos   = NeverSeeded;
  gate_result_t gate_results_q [$];
  gate_result_t want;
  int unsigned  fail_cnt = 0;
  int unsigned  open_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign open_count_o = open_cnt;

  function automatic void fill_words(input logic [31:0] s);
    int unsigned i;
    logic [31:0] p;
    mt_words[0] = s;
    for (i = 1; i < StateLen; i++) begin
      p = mt_words[i-1];
      mt_words[i] = InitMult * (p ^ (p >> 30)) + i;
    end
    mt_pos = StateLen;
  endfunction

  function automatic void regen_words();
    int unsigned k;
    logic [31:0] y;
    logic [31:0] v;
    for (k = 0; k < StateLen; k++) begin
      y = (mt_words[k] & UpperMask) | (mt_words[(k + 1) % StateLen] & LowerMask);
      v = mt_words[(k + ShiftSpan) % StateLen] ^ (y >> 1);
      if (y[0]) v = v ^ MatrixA;
      mt_words[k] = v;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] next_tempered();
    logic [31:0] y;
    if (mt_pos >= StateLen) begin
      if (mt_pos != StateLen) fill_words(BootSeed);
      regen_words();
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic gate_result_t predict_gate(input logic k, input logic [31:0] s,
                                                input logic [32:0] thr);
    gate_result_t r;
    if (k == KindReseed) begin
      // negative seeds read as huge unsigned values and clamp too
      fill_words((s > SeedCeil) ? SeedCeil : s);
      r.word = '0;
      r.gate = 1'b0;
    end else begin
      r.word = next_tempered();
      r.gate = ({1'b0, r.word} < thr);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_pos = NeverSeeded;
      gate_results_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        gate_results_q.push_back(predict_gate(kind_i, seed_i, threshold_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (gate_results_q.size() == 0) begin
          $display("%0t: unexpected result, none pending: word %h gate %b",
                   $time, random_word_i, gate_i);
          fail_cnt++;
        end else begin
          want = gate_results_q.pop_front();
          if (random_word_i !== want.word) begin
            $display("%0t: random_word mismatch: expected %h actual %h",
                     $time, want.word, random_word_i);
            fail_cnt++;
          end
          if (gate_i !== want.gate) begin
            $display("%0t: gate mismatch: expected %b actual %b",
                     $time, want.gate, gate_i);
            fail_cnt++;
          end
        end
      end
    end
    open_cnt = gate_results_q.size();
  end

endmodule

// ===== dv/mt19937_probability_gate_tb.sv =====
// stimulus and verdict for the mt19937 probability gate testbench
`timescale 1ns / 1ps

module mt19937_probability_gate_tb;
  import mtpg_pkg::*;

  localparam int unsigned ItemTarget  = 1050;
  // one unbroken draw run after a reseed, long enough to force a second in-place twist
  localparam int unsigned LongRun     = 650;
  localparam int unsigned QuietSpan   = 300;
  localparam int unsigned DrainCycles = 64;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic signed [31:0] seed_i;
  logic        [32:0] threshold_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic        [31:0] random_word_o;
  logic               gate_o;

  logic        no_idle;
  logic        long_done;
  int unsigned fail_count;
  int unsigned open_count;
  int unsigned sent;
  int unsigned pick;

  mt19937_probability_gate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .seed_i        (seed_i),
    .threshold_i   (threshold_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o),
    .gate_o        (gate_o)
  );

  // scoreboard sits beside the block and only watches the two channels
  mtpg_gate_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .seed_i        (seed_i),
    .threshold_i   (threshold_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_i (random_word_o),
    .gate_i        (gate_o),
    .fail_count_o  (fail_count),
    .open_count_o  (open_count)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result side backpressure, about a third of the cycles unless in a quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 35);
    end
  end

  // mostly small in-range seeds, some just above the clamp, some full 32-bit
  // values (half of those negative)
  function automatic logic [31:0] rand_seed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 99);
    if (r < 75) return $urandom_range(100, 300);
    return $urandom;
  endfunction

  // thresholds across the full 33-bit field, with the edges picked often
  function automatic logic [32:0] rand_threshold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return {1'b0, $urandom};
    if (r < 70) return {1'($urandom_range(0, 1)), $urandom};
    if (r < 80) return 33'h0_0000_0000;
    if (r < 90) return 33'h1_0000_0000;
    return 33'h0_ffff_ffff;
  endfunction

  // one request: random idle gap, then hold valid and payload until accepted
  task automatic send_request(input logic k, input logic [31:0] s, input logic [32:0] t);
    while (!no_idle && ($urandom_range(0, 99) < 35)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    seed_i      <= s;
    threshold_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // draws carry a random seed field, which the block must ignore
  task automatic draw_run(input int unsigned n);
    repeat (n) send_request(KindDraw, $urandom, rand_threshold());
  endtask

  // sender holds off until every pending request has produced its result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (open_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KindDraw;
    seed_i      <= '0;
    threshold_i <= '0;
    no_idle     <= 1'b0;
    long_done    = 1'b0;
    sent         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draw with no reseed since reset: boots with the default seed, then twists
    send_request(KindDraw, 32'h0000_0000, 33'h1_0000_0000);
    // threshold zero never gates, max threshold always gates
    send_request(KindDraw, 32'hffff_ffff, 33'h0_0000_0000);
    send_request(KindDraw, 32'h1234_5678, 33'h1_ffff_ffff);
    send_request(KindDraw, 32'h0000_0000, 33'h0_0000_0001);
    send_request(KindDraw, 32'h0000_0000, 33'h0_ffff_ffff);
    // reseed ignores its threshold field
    send_request(KindReseed, 32'd0, 33'h1_ffff_ffff);
    send_request(KindDraw, 32'h0000_0000, 33'h0_8000_0000);
    // top of the seed range, then the clamp from above and from negatives
    send_request(KindReseed, 32'd99, 33'h0_0000_0000);
    send_request(KindDraw, 32'h0000_0000, 33'h0_8000_0000);
    send_request(KindReseed, 32'd100, 33'h0_5555_5555);
    send_request(KindDraw, 32'h0000_0000, 33'h0_8000_0000);
    send_request(KindReseed, 32'hffff_ffff, 33'h0_0000_0000);
    send_request(KindDraw, 32'h5a5a_5a5a, 33'h0_8000_0000);
    send_request(KindReseed, 32'h8000_0000, 33'h1_0000_0000);
    send_request(KindDraw, 32'ha5a5_a5a5, 33'h0_8000_0000);
    send_request(KindReseed, 32'h7fff_ffff, 33'h0_ffff_ffff);
    send_request(KindDraw, 32'h0000_0000, 33'h1_0000_0000);
    send_request(KindReseed, 32'd1, 33'h0_0000_0000);
    send_request(KindDraw, 32'h0000_0000, 33'h0_0000_0000);
    send_request(KindDraw, 32'h0000_0000, 33'h1_ffff_ffff);

    // full stop: nothing in flight before the random part starts
    wait_drained();

    while (sent < ItemTarget) begin
      if (!long_done && (sent >= 300)) begin
        // long unbroken run, its first part with no idling on either side
        send_request(KindReseed, rand_seed(), rand_threshold());
        no_idle <= 1'b1;
        draw_run(QuietSpan);
        no_idle <= 1'b0;
        draw_run(LongRun - QuietSpan);
        long_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // well-formed: reseed then a short run of draws
          send_request(KindReseed, rand_seed(), rand_threshold());
          draw_run($urandom_range(1, 30));
        end else if (pick < 85) begin
          // broken: back-to-back reseeds with no draw between
          send_request(KindReseed, rand_seed(), rand_threshold());
          send_request(KindReseed, rand_seed(), rand_threshold());
        end else begin
          // draws continuing from wherever the state was left
          draw_run($urandom_range(1, 60));
        end
      end
    end

    wait_drained();
    // allow any stray late result to show up
    repeat (DrainCycles) @(posedge clk_i);
    if ((fail_count == 0) && (open_count == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== mt19937_probability_gate.f =====
hw/rtl/mtpg_pkg.sv
hw/rtl/mt19937_probability_gate.sv
dv/mtpg_gate_checker.sv
dv/mt19937_probability_gate_tb.sv
